// ===== sv/mf3_pkg.sv =====
// Package for the 3x3 median filter core.
// Holds shared constants, register indexes and the border flag type.
// No dependencies; imported by every module of the block.
package mf3_pkg;

    // Default parameter values for the top level.
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Window geometry: nine taps, three per row.
    localparam int WIN_TAPS = 9;
    localparam int WIN_COLS = 3;

    // Fixed field widths of the ports.
    localparam int ROW_BITS      = 16;
    localparam int OUT_COL_BITS  = 10;
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Image size limits and reset values.
    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Pipeline depth of the median network and depth of the result queue.
    localparam int MED_STAGES = 3;
    localparam int OQ_DEPTH   = 8;

    // Border copies that go with one interior result.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic frame_end;
    } border_t;

endpackage

// ===== sv/mf3_lines.sv =====
// Line stores and 3x3 window register of the median filter.
// Two synchronous memories with a registered read, written back in the cycle after the read.
// Depends on mf3_pkg.
module mf3_lines
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_fire,
    input  logic [$clog2(MAX_WIDTH)-1:0]        col,
    input  logic signed [SAMPLE_BITS-1:0]       pixel,
    output logic signed [SAMPLE_BITS-1:0]       win [WIN_TAPS]
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    // Line store memories: upper holds row r-2, middle holds row r-1.
    logic signed [SAMPLE_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];

    logic signed [SAMPLE_BITS-1:0] up_rd_reg;
    logic signed [SAMPLE_BITS-1:0] mid_rd_reg;
    logic signed [SAMPLE_BITS-1:0] last_up_wr_reg;
    logic signed [SAMPLE_BITS-1:0] last_mid_wr_reg;
    logic signed [SAMPLE_BITS-1:0] s1_pix_reg;
    logic [COL_BITS-1:0]           s1_addr_reg;
    logic                          s1_valid_reg;
    logic                          fwd_reg;
    logic signed [SAMPLE_BITS-1:0] up_val;
    logic signed [SAMPLE_BITS-1:0] mid_val;
    logic signed [SAMPLE_BITS-1:0] win_reg [WIN_TAPS];

    // Read at acceptance, write back the rotated column in the next cycle.
    always_ff @(posedge clk)
    begin
        if (pixel_fire)
        begin
            up_rd_reg  <= upper_mem[col];
            mid_rd_reg <= middle_mem[col];
            s1_pix_reg <= pixel;
            s1_addr_reg <= col;
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= mid_val;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
            last_up_wr_reg          <= mid_val;
            last_mid_wr_reg         <= s1_pix_reg;
        end
    end

    // Stage valid and the same-address forwarding flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pixel_fire;
            if (pixel_fire)
            begin
                fwd_reg <= s1_valid_reg && (s1_addr_reg == col);
            end
        end
    end

    // A read that met a write to the same entry takes the written values.
    assign up_val  = fwd_reg ? last_up_wr_reg  : up_rd_reg;
    assign mid_val = fwd_reg ? last_mid_wr_reg : mid_rd_reg;

    // Window shift: each row moves one column left, new column enters on the right.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int k = 0; k < WIN_COLS; k++)
            begin
                win_reg[k*WIN_COLS]     <= win_reg[k*WIN_COLS + 1];
                win_reg[k*WIN_COLS + 1] <= win_reg[k*WIN_COLS + 2];
            end
            win_reg[2] <= up_val;
            win_reg[5] <= mid_val;
            win_reg[8] <= s1_pix_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            win[i] = win_reg[i];
        end
    end

endmodule

// ===== sv/mf3_median.sv =====
// Three stage median-of-nine network for the median filter.
// Sorts each window row, then combines row minima, medians and maxima.
// Depends on mf3_pkg.
module mf3_median
    import mf3_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic signed [SAMPLE_BITS-1:0] win [WIN_TAPS],
    output logic signed [SAMPLE_BITS-1:0] median
);

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    smp_t lo_a_reg [WIN_COLS];
    smp_t md_a_reg [WIN_COLS];
    smp_t hi_a_reg [WIN_COLS];
    smp_t lo_b_reg;
    smp_t md_b_reg;
    smp_t hi_b_reg;
    smp_t med_reg;

    function automatic smp_t min2(smp_t a, smp_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic smp_t max2(smp_t a, smp_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic smp_t med3(smp_t a, smp_t b, smp_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Stage A: sort each row of three.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WIN_COLS; k++)
        begin
            lo_a_reg[k] <= min2(min2(win[k*WIN_COLS], win[k*WIN_COLS + 1]),
                                win[k*WIN_COLS + 2]);
            md_a_reg[k] <= med3(win[k*WIN_COLS], win[k*WIN_COLS + 1],
                                win[k*WIN_COLS + 2]);
            hi_a_reg[k] <= max2(max2(win[k*WIN_COLS], win[k*WIN_COLS + 1]),
                                win[k*WIN_COLS + 2]);
        end
    end

    // Stage B: largest minimum, median of medians, smallest maximum.
    always_ff @(posedge clk)
    begin
        lo_b_reg <= max2(max2(lo_a_reg[0], lo_a_reg[1]), lo_a_reg[2]);
        md_b_reg <= med3(md_a_reg[0], md_a_reg[1], md_a_reg[2]);
        hi_b_reg <= min2(min2(hi_a_reg[0], hi_a_reg[1]), hi_a_reg[2]);
    end

    // Stage C: the median of those three is the fifth smallest of nine.
    always_ff @(posedge clk)
    begin
        med_reg <= med3(lo_b_reg, md_b_reg, hi_b_reg);
    end

    assign median = med_reg;

endmodule

// ===== sv/median_filter_3x3_core.sv =====
// Channel   Signals                                    Direction  Beat
// config    cfg_we, cfg_index, cfg_data                in         write when cfg_we
// pixel     pixel_valid/ready, pixel_value             in         one raster sample
// result    result_valid/ready, out_row, out_col,      out        one output sample
//           out_value, last_of_run, frame_done
//
// One pixel beat is taken per cycle while pixel_ready is high; the line store memories are read at
// acceptance and written back in the next cycle, so a new pixel can follow every cycle.
// A pixel's first result beat passes through the line store read, the window, three median
// stages, the result queue and the output register.
// Border pixels cause up to nine result beats, sent one per cycle while result_ready is high
// from an eight-entry queue; pixel_ready drops while the queue plus the results in flight would fill it.
// Reset clears counters and window; line store contents are undefined until written.
// Depends on mf3_pkg, mf3_lines and mf3_median.
module median_filter_3x3_core
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic signed [SAMPLE_BITS-1:0] pixel_value,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [ROW_BITS-1:0]           out_row,
    output logic [OUT_COL_BITS-1:0]       out_col,
    output logic signed [SAMPLE_BITS-1:0] out_value,
    output logic                          last_of_run,
    output logic                          frame_done
);

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WEFF_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int RST_WEFF   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int Q_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int Q_CNT_BITS = $clog2(OQ_DEPTH + 1);
    localparam int OCC_BITS   = $clog2(OQ_DEPTH + MED_STAGES + 3);

    // Copy phases within one interior result: before, at and after the center.
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_CTR  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    typedef struct packed {
        logic                res;
        logic [ROW_BITS-1:0] cr;
        logic [COL_BITS-1:0] cc;
        border_t             brd;
    } tag_t;

    logic                          pixel_fire;
    logic [WIDTH_BITS-1:0]         width_raw;
    logic [HEIGHT_BITS-1:0]        height_raw;
    logic [WEFF_BITS-1:0]          w_eff;
    logic [COL_BITS-1:0]           col_last_next;
    logic [ROW_BITS-1:0]           row_last_next;
    logic [COL_BITS-1:0]           col_last_reg;
    logic [ROW_BITS-1:0]           row_last_reg;
    logic [COL_BITS-1:0]           col_count_reg;
    logic [ROW_BITS-1:0]           row_count_reg;
    logic                          s1_res_reg;
    logic [ROW_BITS-1:0]           s1_row_reg;
    logic [COL_BITS-1:0]           s1_col_reg;
    tag_t                          tag_s2;
    tag_t                          tag_reg [MED_STAGES+1];
    logic signed [SAMPLE_BITS-1:0] win [WIN_TAPS];
    logic signed [SAMPLE_BITS-1:0] median;
    logic [OCC_BITS-1:0]           occupancy;

    logic signed [SAMPLE_BITS-1:0] q_value [OQ_DEPTH];
    tag_t                          q_tag   [OQ_DEPTH];
    logic [Q_PTR_BITS-1:0]         wr_ptr_reg;
    logic [Q_PTR_BITS-1:0]         rd_ptr_reg;
    logic [Q_CNT_BITS-1:0]         count_reg;
    logic                          push;
    logic                          pop;

    tag_t                          head_tag;
    logic [1:0]                    rp_reg;
    logic [1:0]                    cp_reg;
    logic                          fresh_reg;
    logic [1:0]                    first_rp;
    logic [1:0]                    first_cp;
    logic [1:0]                    rp;
    logic [1:0]                    cp;
    logic                          row_done;
    logic                          col_done;
    logic                          beat_load;
    logic [ROW_BITS-1:0]           beat_row;
    logic [COL_BITS-1:0]           beat_col;

    logic                          out_valid_reg;
    logic [ROW_BITS-1:0]           out_row_reg;
    logic [OUT_COL_BITS-1:0]       out_col_reg;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic                          last_reg;
    logic                          fdone_reg;

    assign pixel_fire = pixel_valid && pixel_ready;

    // Effective image size from a configuration write: clamp to the legal range.
    always_comb
    begin
        width_raw  = cfg_data[WIDTH_BITS-1:0];
        height_raw = cfg_data[HEIGHT_BITS-1:0];
        priority if (width_raw < WIDTH_BITS'(MIN_DIM))
        begin
            w_eff = WEFF_BITS'(MIN_DIM);
        end
        else if (32'(width_raw) > MAX_WIDTH)
        begin
            w_eff = WEFF_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WEFF_BITS'(width_raw);
        end
        col_last_next = COL_BITS'(w_eff - WEFF_BITS'(1));
        if (height_raw < HEIGHT_BITS'(MIN_DIM))
        begin
            row_last_next = ROW_BITS'(MIN_DIM - 1);
        end
        else
        begin
            row_last_next = ROW_BITS'(height_raw - HEIGHT_BITS'(1));
        end
    end

    // Configuration registers and raster counters; a write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg  <= COL_BITS'(RST_WEFF - 1);
            row_last_reg  <= ROW_BITS'(RESET_HEIGHT - 1);
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  col_last_reg <= col_last_next;
                REG_IMAGE_HEIGHT: row_last_reg <= row_last_next;
            endcase
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (pixel_fire)
        begin
            if (col_count_reg == col_last_reg)
            begin
                col_count_reg <= '0;
                row_count_reg <= (row_count_reg == row_last_reg) ?
                                 '0 : row_count_reg + ROW_BITS'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_BITS'(1);
            end
        end
    end

    // Stage 1 position, alongside the line store read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_res_reg <= 1'b0;
        end
        else
        begin
            s1_res_reg <= pixel_fire && (row_count_reg >= ROW_BITS'(2))
                          && (col_count_reg >= COL_BITS'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_fire)
        begin
            s1_row_reg <= row_count_reg;
            s1_col_reg <= col_count_reg;
        end
    end

    // Window center and the border copies that it feeds.
    always_comb
    begin
        tag_s2.res           = s1_res_reg;
        tag_s2.cr            = s1_row_reg - ROW_BITS'(1);
        tag_s2.cc            = s1_col_reg - COL_BITS'(1);
        tag_s2.brd.top       = (s1_row_reg == ROW_BITS'(2));
        tag_s2.brd.bottom    = (s1_row_reg == row_last_reg);
        tag_s2.brd.left      = (s1_col_reg == COL_BITS'(2));
        tag_s2.brd.right     = (s1_col_reg == col_last_reg);
        tag_s2.brd.frame_end = tag_s2.brd.bottom && tag_s2.brd.right;
    end

    // Tags travel beside the window and the median stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= MED_STAGES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_s2;
            for (int i = 1; i <= MED_STAGES; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    mf3_lines #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lines (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_fire (pixel_fire),
        .col        (col_count_reg),
        .pixel      (pixel_value),
        .win        (win)
    );

    mf3_median #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .clk    (clk),
        .win    (win),
        .median (median)
    );

    // Credit check: queue entries plus results still in flight.
    always_comb
    begin
        occupancy = OCC_BITS'(count_reg) + OCC_BITS'(s1_res_reg);
        for (int i = 0; i <= MED_STAGES; i++)
        begin
            occupancy = occupancy + OCC_BITS'(tag_reg[i].res);
        end
    end

    assign pixel_ready = (occupancy < OCC_BITS'(OQ_DEPTH));

    // Result queue: one entry per interior median.
    assign push = tag_reg[MED_STAGES].res;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_value[wr_ptr_reg] <= median;
            q_tag[wr_ptr_reg]   <= tag_reg[MED_STAGES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            end
            count_reg <= count_reg + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
        end
    end

    // Beat expansion: walk the copy rows and columns of the head entry in raster order.
    assign head_tag  = q_tag[rd_ptr_reg];
    assign first_rp  = head_tag.brd.top  ? PH_LOW : PH_CTR;
    assign first_cp  = head_tag.brd.left ? PH_LOW : PH_CTR;
    assign rp        = fresh_reg ? first_rp : rp_reg;
    assign cp        = fresh_reg ? first_cp : cp_reg;
    assign row_done  = (rp == PH_HIGH) || ((rp != PH_HIGH) && (rp != PH_LOW)
                       && !head_tag.brd.bottom);
    assign col_done  = (cp == PH_HIGH) || ((cp != PH_HIGH) && (cp != PH_LOW)
                       && !head_tag.brd.right);
    assign beat_load = (count_reg != '0) && (!out_valid_reg || result_ready);
    assign pop       = beat_load && row_done && col_done;

    always_comb
    begin
        unique case (rp)
            PH_LOW:  beat_row = '0;
            PH_CTR:  beat_row = head_tag.cr;
            default: beat_row = head_tag.cr + ROW_BITS'(1);
        endcase
        unique case (cp)
            PH_LOW:  beat_col = '0;
            PH_CTR:  beat_col = head_tag.cc;
            default: beat_col = head_tag.cc + COL_BITS'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
            rp_reg    <= PH_CTR;
            cp_reg    <= PH_CTR;
        end
        else if (beat_load)
        begin
            if (col_done)
            begin
                cp_reg <= first_cp;
                if (row_done)
                begin
                    fresh_reg <= 1'b1;
                end
                else
                begin
                    rp_reg    <= rp + 2'd1;
                    fresh_reg <= 1'b0;
                end
            end
            else
            begin
                cp_reg    <= cp + 2'd1;
                rp_reg    <= rp;
                fresh_reg <= 1'b0;
            end
        end
    end

    // Output register: the queue keeps taking medians while a beat waits here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_load)
        begin
            out_row_reg   <= beat_row;
            out_col_reg   <= OUT_COL_BITS'(beat_col);
            out_value_reg <= q_value[rd_ptr_reg];
            last_reg      <= row_done && col_done;
            fdone_reg     <= row_done && col_done && head_tag.brd.frame_end;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_value    = out_value_reg;
    assign last_of_run  = last_reg;
    assign frame_done   = fdone_reg;

`ifndef NO_ASSERTIONS
    // The credit check keeps the queue from overflowing.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < Q_CNT_BITS'(OQ_DEPTH)))
        else $error("median filter: result queue written while full");

    // Queue entries plus results in flight never exceed the queue depth.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OCC_BITS'(OQ_DEPTH))
        else $error("median filter: queue credit exceeded");

    // A frame ends only on the last beat of a pixel's run.
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_done) |-> last_of_run)
        else $error("median filter: frame_done without last_of_run");

    // The head entry is released only when the queue holds one.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("median filter: pop from empty queue");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for median_filter_3x3_core: raster pixel beats with random gaps
// and result back-pressure, every result beat predicted in place and compared by field.
// Depends on mf3_pkg and the median_filter_3x3_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int SB           = DEF_SAMPLE_BITS;
    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MID_RANK     = WIN_TAPS / 2;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 80;
    localparam int FIRST_HOLD   = 20;
    localparam int HOLD_SPACING = 400;
    localparam int RANDOM_BEATS = 210;
    localparam int RANDOM_CAP   = 300;
    localparam int NO_CAP       = 1 << 30;
    localparam int LIMIT_NS     = 10_000_000;

    typedef logic signed [SB-1:0] sample_t;

    typedef struct {
        logic [ROW_BITS-1:0]     row;
        logic [OUT_COL_BITS-1:0] col;
        sample_t                 value;
        logic                    last;
        logic                    done;
    } median_beat_t;

    typedef struct {
        sample_t px;
        bit      typed;
        sample_t median;
    } directed_row_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = REG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;
    logic                     pixel_valid  = 1'b0;
    logic                     pixel_ready;
    sample_t                  pixel_value  = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic [ROW_BITS-1:0]      out_row;
    logic [OUT_COL_BITS-1:0]  out_col;
    sample_t                  out_value;
    logic                     last_of_run;
    logic                     frame_done;

    // Filter state mirrored by the predictor.
    sample_t                line_upper [MAX_W];
    sample_t                line_middle [MAX_W];
    sample_t                window [WIN_TAPS];
    int                     row_pos;
    int                     col_pos;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;

    median_beat_t median_due_q [$];
    int           mismatch_count = 0;
    bit           steady_sender  = 1'b0;

    // With both sizes below the minimum the image is 3x3, so the ninth beat of each
    // frame completes the only window and yields all nine positions at once.
    directed_row_t directed_rows [21] = '{
        '{16'sh7FFF, 1'b0, 16'sh0000}, '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000}, '{16'sd100,  1'b0, 16'sh0000},
        '{-16'sd100, 1'b0, 16'sh0000}, '{16'sh7FFF, 1'b0, 16'sh0000},
        '{16'sh8000, 1'b0, 16'sh0000}, '{16'sd5,    1'b0, 16'sh0000},
        '{-16'sd5,   1'b1, 16'sh0000},
        // Second frame after the wrap: five maxima against four minima.
        '{16'sh7FFF, 1'b0, 16'sh0000}, '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000}, '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000}, '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000}, '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b1, 16'sh7FFF},
        // Top row of a third frame: no window yet, so no result.
        '{16'shFFFF, 1'b0, 16'sh0000}, '{16'sh0001, 1'b0, 16'sh0000},
        '{16'shFFFF, 1'b0, 16'sh0000}
    };

    median_filter_3x3_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    // 250 MHz clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int active_height();
        return (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
    endfunction

    // Advances the filter by one pixel and queues the result beats it causes.
    // A typed median from the stimulus table replaces the computed one.
    function automatic void predict_medians(input sample_t px, input bit typed,
                                            input sample_t typed_median);
        int      w, h, cr, cc, n_rows, n_cols, lower, same;
        int      rows [3];
        int      cols [3];
        sample_t up, mid, med;
        median_beat_t beat;
        w   = active_width();
        h   = active_height();
        up  = line_upper[col_pos];
        mid = line_middle[col_pos];
        line_upper[col_pos]  = mid;
        line_middle[col_pos] = px;

        // Shift the window one column left; the new column enters on the right.
        for (int k = 0; k < WIN_TAPS; k += WIN_COLS)
        begin
            window[k]     = window[k + 1];
            window[k + 1] = window[k + 2];
        end
        window[WIN_COLS - 1]     = up;
        window[2 * WIN_COLS - 1] = mid;
        window[3 * WIN_COLS - 1] = px;

        if (row_pos >= 2 && col_pos >= 2)
        begin
            // The median is the tap with at most MID_RANK taps below it and
            // more than MID_RANK taps at or below it.
            med = window[0];
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                lower = 0;
                same  = 0;
                for (int j = 0; j < WIN_TAPS; j++)
                begin
                    if (window[j] < window[i])
                        lower++;
                    else if (window[j] == window[i])
                        same++;
                end
                if (lower <= MID_RANK && lower + same > MID_RANK)
                    med = window[i];
            end
            if (typed)
                med = typed_median;

            // Border copies ride along with the interior result next to them.
            cr     = row_pos - 1;
            cc     = col_pos - 1;
            n_rows = 0;
            n_cols = 0;
            if (cr == 1)
            begin
                rows[n_rows] = 0;
                n_rows++;
            end
            rows[n_rows] = cr;
            n_rows++;
            if (cr == h - 2)
            begin
                rows[n_rows] = h - 1;
                n_rows++;
            end
            if (cc == 1)
            begin
                cols[n_cols] = 0;
                n_cols++;
            end
            cols[n_cols] = cc;
            n_cols++;
            if (cc == w - 2)
            begin
                cols[n_cols] = w - 1;
                n_cols++;
            end
            for (int a = 0; a < n_rows; a++)
            begin
                for (int b = 0; b < n_cols; b++)
                begin
                    beat.row   = ROW_BITS'(rows[a]);
                    beat.col   = OUT_COL_BITS'(cols[b]);
                    beat.value = med;
                    beat.last  = (a == n_rows - 1) && (b == n_cols - 1);
                    beat.done  = beat.last && row_pos == h - 1 && col_pos == w - 1;
                    median_due_q.push_back(beat);
                end
            end
        end

        // Raster counters wrap at the end of the row and of the frame.
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endfunction

    function automatic sample_t random_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return sample_t'($urandom);
        // Narrow range so that windows hold many equal samples.
        if (roll < 8)
            return sample_t'(int'($urandom_range(0, 6)) - 3);
        unique case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return -16'sd1;
            default: return '0;
        endcase
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Register write; the frame restarts from the top left corner.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = data[WIDTH_BITS-1:0];
        else
            height_reg = data[HEIGHT_BITS-1:0];
        row_pos = 0;
        col_pos = 0;
        @(posedge clk);
    endtask

    // Offers one pixel beat, after a random gap unless steady_sender is set, and holds it until accepted.
    task automatic send_pixel(input sample_t px, input bit typed, input sample_t typed_median);
        int gap, roll;
        gap = 0;
        if (!steady_sender)
        begin
            roll = $urandom_range(0, 19);
            if (roll >= 19)
                gap = $urandom_range(8, 30);
            else if (roll >= 14)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= px;
        do
            @(posedge clk);
        while (pixel_ready !== 1'b1);
        predict_medians(px, typed, typed_median);
    endtask

    // Waits until every queued result has arrived and the pipeline has emptied.
    task automatic wait_for_idle();
        pixel_valid <= 1'b0;
        while (median_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One image geometry: optional register writes, then whole frames plus a tail.
    task automatic run_geometry(input bit wr_w, input logic [CFG_DATA_BITS-1:0] w_data,
                                input bit wr_h, input logic [CFG_DATA_BITS-1:0] h_data,
                                input int frames, input int extra, input int max_pixels,
                                output int sent);
        wait_for_idle();
        if (wr_w)
            write_register(REG_IMAGE_WIDTH, w_data);
        if (wr_h)
            write_register(REG_IMAGE_HEIGHT, h_data);
        sent = frames * active_width() * active_height() + extra;
        if (sent > max_pixels)
            sent = extra + 3 * active_width();
        repeat (sent) send_pixel(random_sample(), 1'b0, '0);
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        int                       sent, random_pixels, frames, extra, roll;
        bit                       wr_w, wr_h;
        logic [CFG_DATA_BITS-1:0] w_data, h_data;
        width_reg  = WIDTH_BITS'(RESET_WIDTH);
        height_reg = HEIGHT_BITS'(RESET_HEIGHT);
        row_pos    = 0;
        col_pos    = 0;
        foreach (window[i])
            window[i] = '0;
        foreach (line_upper[i])
        begin
            line_upper[i]  = '0;
            line_middle[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: both sizes below the minimum, then the table.
        write_register(REG_IMAGE_WIDTH, 16'd0);
        write_register(REG_IMAGE_HEIGHT, 16'd1);
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].median);

        // Geometry extremes: short runs at full and saturated width, a tall narrow
        // image, then height zero.
        run_geometry(1'b1, 16'd1024, 1'b1, 16'd3, 0, 10, NO_CAP, sent);
        run_geometry(1'b1, 16'hFFFF, 1'b1, 16'd2, 0, 5, NO_CAP, sent);
        // The first long result hold-off falls in this run, so the queue fills
        // while pixels keep coming and pixel_ready must drop.
        steady_sender = 1'b1;
        run_geometry(1'b1, 16'd3, 1'b1, 16'hFFFF, 0, 60, NO_CAP, sent);
        steady_sender = 1'b0;
        run_geometry(1'b0, '0, 1'b1, 16'd0, 2, 0, NO_CAP, sent);

        // Random part: mostly whole small frames, some cut short by a new geometry.
        random_pixels = 0;
        while (random_pixels < RANDOM_BEATS)
        begin
            roll = $urandom_range(0, 9);
            wr_w = (roll != 0);
            wr_h = (roll != 1);
            roll = $urandom_range(0, 9);
            if (roll < 8)
                w_data = 16'($urandom_range(3, 12));
            else if (roll == 8)
                w_data = 16'($urandom_range(0, 2));
            else
                w_data = {5'($urandom), 11'($urandom_range(3, 8))};
            roll = $urandom_range(0, 9);
            if (roll < 7)
                h_data = 16'($urandom_range(3, 7));
            else if (roll == 7)
                h_data = 16'($urandom_range(0, 2));
            else if (roll == 8)
                h_data = 16'hFFFF;
            else
                h_data = 16'($urandom_range(8, 65535));
            frames        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
            extra         = $urandom_range(0, 20);
            steady_sender = ($urandom_range(0, 3) == 0);
            run_geometry(wr_w, w_data, wr_h, h_data, frames, extra, RANDOM_CAP, sent);
            random_pixels += sent;
        end

        wait_for_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side ready: random stalls, free-running stretches and long hold-offs.
    initial
    begin : result_pacing
        int   run_left, roll, beats, hold_at;
        logic level;
        run_left = 0;
        level    = 1'b1;
        beats    = 0;
        hold_at  = FIRST_HOLD;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready === 1'b1)
                beats++;
            if (beats >= hold_at)
            begin
                // Long hold-off: the result queue fills and pixel_ready must drop.
                hold_at += HOLD_SPACING;
                level    = 1'b0;
                run_left = LONG_HOLD;
            end
            else if (run_left <= 0)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6)
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 30);
                end
                else if (roll < 9)
                begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 3);
                end
                else
                begin
                    level    = 1'b0;
                    run_left = $urandom_range(10, 40);
                end
            end
            result_ready <= level;
            run_left--;
        end
    end

    // Compares every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        median_beat_t due;
        if (rst_n && $isunknown(result_valid))
        begin
            log_mismatch("result_valid is unknown");
        end
        else if (rst_n && result_valid && result_ready)
        begin
            if (median_due_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected beat row %0d col %0d value %0d",
                                       out_row, out_col, out_value));
            end
            else
            begin
                due = median_due_q.pop_front();
                if (out_row !== due.row || out_col !== due.col || out_value !== due.value
                    || last_of_run !== due.last || frame_done !== due.done)
                    log_mismatch($sformatf(
                        "row/col/value/last/done got %0d/%0d/%0d/%b/%b want %0d/%0d/%0d/%b/%b",
                        out_row, out_col, out_value, last_of_run, frame_done,
                        due.row, due.col, due.value, due.last, due.done));
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
